// File: hdl/ggc_pkg.sv
// shared opcode, status and pending-word types for the graph coloring block
package ggc_pkg;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_END   = 3'd1,
		OP_COLOR = 3'd2,
		OP_RDV   = 3'd3,
		OP_RDT   = 3'd4,
		OP_CLR   = 3'd5
	} opcode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOCOL = 2'd2;

	typedef enum logic [1:0] {
		K_FIXED,
		K_VERTEX,
		K_TALLY
	} rd_kind_t;

	// result word waiting for its memory read
	typedef struct packed {
		rd_kind_t    kind;
		logic [1:0]  status;
		logic [9:0]  ans;
		logic [10:0] total;
	} pend_t;

endpackage

// File: hdl/ggc_ram.sv
// generic simple dual port ram, one write and one registered read port
module ggc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/greedy_graph_coloring.sv
// greedy graph coloring engine: adjacency load, ordering, coloring and reads
//
//  channel  | direction | contents
//  s_*      | in        | command word: opcode, column, query_index
//  m_*      | out       | result word: status, answer_index, color_value, vertex_tally, color_total
//  cfg_*    | in        | order_mode register write
//
// load, read and clear words pass at one per cycle while no pending answer waits on a stalled output;
// a read is taken into a single pending stage in front of the output register, which then holds the answer.
// color first sweeps the color memories, then reads each row length to build the order, in
// natural mode as it comes, or in longest row mode moving each vertex past the shorter rows, then
// colors each vertex by marking the colors of its neighbours and taking the first color not marked.
// reset and clear need no memory pass; the color memories are swept at each color word.
// input stalls while coloring runs; the output register decouples a stalled consumer.
module greedy_graph_coloring #(
	parameter int MAXV = 1024,
	parameter int MAXE = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // opcode[2:0], column[12:3], query_index[22:13]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[1:0], answer_index[11:2], color_value[21:12],
	                               // vertex_tally[32:22], color_total[43:33]
	input  logic        cfg_wen,
	input  logic        cfg_wdata
);

	localparam int VW = $clog2(MAXV);
	localparam int NW = $clog2(MAXV + 1);
	localparam int KW = $clog2(MAXE);
	localparam int EW = $clog2(MAXE + 1);
	localparam int OW = VW + EW;

	typedef enum logic [3:0] {
		S_IDLE, S_SWEEP, S_LEN_RD, S_LEN, S_CMP, S_PLACE,
		S_C_ORD, S_C_ROW, S_C_RANGE, S_C_NB, S_C_DRAIN, S_C_SRCH, S_C_CHK,
		S_C_TRD, S_C_TWR, S_DONE
	} state_t;

	state_t state_q;
	logic [NW-1:0] rows_q, colors_q, i_q, j_q, c_q;
	logic [EW-1:0] entries_q, len_q, prev_q, k_q, kend_q;
	logic [VW-1:0] sw_q, u_q;
	logic valid_q, mode_q, p1_q, p2_q;
	ggc_pkg::pend_t s1_q;
	logic s1_v_q;
	logic m_tvalid_q;
	logic [1:0] o_status_q;
	logic [9:0] o_ans_q, o_cval_q;
	logic [10:0] o_tally_q, o_total_q;

	// memory ports
	logic nb_we, nb_re, re_we, re_re, ord_we, ord_re, vc_we, vc_re, sn_we, sn_re, ta_we, ta_re;
	logic [KW-1:0] nb_waddr, nb_raddr;
	logic [VW-1:0] nb_wdata, nb_rdata;
	logic [VW-1:0] re_waddr, re_raddr, ord_waddr, ord_raddr, vc_waddr, vc_raddr;
	logic [VW-1:0] sn_waddr, sn_raddr, ta_waddr, ta_raddr;
	logic [EW-1:0] re_wdata, re_rdata;
	logic [OW-1:0] ord_wdata, ord_rdata;
	logic [NW-1:0] vc_wdata, vc_rdata, sn_wdata, sn_rdata, ta_wdata, ta_rdata;

	ggc_ram #(.WIDTH(VW), .DEPTH(MAXE)) u_nb (.clk, .we(nb_we), .waddr(nb_waddr),
		.wdata(nb_wdata), .re(nb_re), .raddr(nb_raddr), .rdata(nb_rdata));
	ggc_ram #(.WIDTH(EW), .DEPTH(MAXV)) u_rowend (.clk, .we(re_we), .waddr(re_waddr),
		.wdata(re_wdata), .re(re_re), .raddr(re_raddr), .rdata(re_rdata));
	ggc_ram #(.WIDTH(OW), .DEPTH(MAXV)) u_order (.clk, .we(ord_we), .waddr(ord_waddr),
		.wdata(ord_wdata), .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata));
	ggc_ram #(.WIDTH(NW), .DEPTH(MAXV)) u_vcolor (.clk, .we(vc_we), .waddr(vc_waddr),
		.wdata(vc_wdata), .re(vc_re), .raddr(vc_raddr), .rdata(vc_rdata));
	ggc_ram #(.WIDTH(NW), .DEPTH(MAXV)) u_seen (.clk, .we(sn_we), .waddr(sn_waddr),
		.wdata(sn_wdata), .re(sn_re), .raddr(sn_raddr), .rdata(sn_rdata));
	ggc_ram #(.WIDTH(NW), .DEPTH(MAXV)) u_tally (.clk, .we(ta_we), .waddr(ta_waddr),
		.wdata(ta_wdata), .re(ta_re), .raddr(ta_raddr), .rdata(ta_rdata));

	ggc_pkg::opcode_t op;
	logic [9:0] col, qidx;
	logic out_free, in_fire, add_ok, end_ok, rdv_ok, rdt_ok, direct, last_i, shift;
	logic s1_set, done_fire;
	logic [EW-1:0] len_now, d_len;
	logic [NW-1:0] jm1, jm2, i_inc;

	assign op       = ggc_pkg::opcode_t'(s_tdata[2:0]);
	assign col      = s_tdata[12:3];
	assign qidx     = s_tdata[22:13];
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && (!s1_v_q || out_free);
	assign in_fire  = s_tvalid && s_tready;
	assign add_ok   = (rows_q < NW'(MAXV)) && (entries_q < EW'(MAXE)) &&
	                  (32'(col) < 32'(MAXV));
	assign end_ok   = rows_q < NW'(MAXV);
	assign rdv_ok   = valid_q && (32'(qidx) < 32'(rows_q));
	assign rdt_ok   = valid_q && (32'(qidx) < 32'(colors_q));
	assign len_now  = re_rdata - prev_q;
	assign direct   = !mode_q || (i_q == '0);
	assign d_len    = ord_rdata[EW-1:0];
	assign shift    = d_len < len_q;
	assign jm1      = j_q - NW'(1);
	assign jm2      = j_q - NW'(2);
	assign i_inc    = i_q + NW'(1);
	assign last_i   = i_inc == rows_q;
	// words that leave a pending answer: failed loads and all reads
	assign s1_set   = in_fire && ((op == ggc_pkg::OP_ADD && !add_ok) ||
	                  (op == ggc_pkg::OP_END && !end_ok) ||
	                  op == ggc_pkg::OP_RDV || op == ggc_pkg::OP_RDT);
	assign done_fire = (state_q == S_DONE) && !s1_v_q && out_free;

	always_comb begin
		nb_we = 1'b0; nb_re = 1'b0; re_we = 1'b0; re_re = 1'b0;
		ord_we = 1'b0; ord_re = 1'b0; vc_we = 1'b0; vc_re = 1'b0;
		sn_we = 1'b0; sn_re = 1'b0; ta_we = 1'b0; ta_re = 1'b0;
		nb_waddr = entries_q[KW-1:0];
		nb_wdata = VW'(col);
		nb_raddr = k_q[KW-1:0];
		re_waddr = rows_q[VW-1:0];
		re_wdata = entries_q;
		re_raddr = i_q[VW-1:0];
		ord_waddr = i_q[VW-1:0];
		ord_wdata = {i_q[VW-1:0], len_q};
		ord_raddr = i_q[VW-1:0];
		vc_waddr = sw_q;
		vc_wdata = NW'(MAXV);
		vc_raddr = VW'(qidx);
		sn_waddr = sw_q;
		sn_wdata = NW'(MAXV);
		sn_raddr = c_q[VW-1:0];
		ta_waddr = sw_q;
		ta_wdata = '0;
		ta_raddr = VW'(qidx);
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (op)
						ggc_pkg::OP_ADD: nb_we = add_ok;
						ggc_pkg::OP_END: re_we = end_ok;
						ggc_pkg::OP_RDV: vc_re = rdv_ok;
						ggc_pkg::OP_RDT: ta_re = rdt_ok;
						default: ;
					endcase
				end
			end
			S_SWEEP: begin
				vc_we = 1'b1;
				sn_we = 1'b1;
				ta_we = 1'b1;
			end
			S_LEN_RD: re_re = 1'b1;
			S_LEN: begin
				ord_wdata = {i_q[VW-1:0], len_now};
				if (direct) begin
					ord_we = 1'b1;
				end else begin
					ord_re = 1'b1;
					ord_raddr = jm1[VW-1:0] - VW'(0) + (i_q[VW-1:0] - j_q[VW-1:0]);
				end
			end
			S_CMP: begin
				ord_we = 1'b1;
				ord_waddr = j_q[VW-1:0];
				if (shift) begin
					ord_wdata = ord_rdata;
					if (j_q != NW'(1)) begin
						ord_re = 1'b1;
						ord_raddr = jm2[VW-1:0];
					end
				end
			end
			S_PLACE: begin
				ord_we = 1'b1;
				ord_waddr = '0;
			end
			S_C_ORD: ord_re = 1'b1;
			S_C_ROW: begin
				re_re = 1'b1;
				re_raddr = ord_rdata[OW-1:EW];
			end
			S_C_NB, S_C_DRAIN: begin
				nb_re = (state_q == S_C_NB) && (k_q != kend_q);
				vc_re = p1_q;
				vc_raddr = nb_rdata;
				sn_we = p2_q && (vc_rdata != NW'(MAXV));
				sn_waddr = vc_rdata[VW-1:0];
				sn_wdata = i_q;
			end
			S_C_SRCH: sn_re = c_q != colors_q;
			S_C_TRD: begin
				ta_re = 1'b1;
				ta_raddr = c_q[VW-1:0];
			end
			S_C_TWR: begin
				ta_we = 1'b1;
				ta_waddr = c_q[VW-1:0];
				ta_wdata = ta_rdata + NW'(1);
				vc_we = 1'b1;
				vc_waddr = u_q;
				vc_wdata = c_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q <= '0; colors_q <= '0; entries_q <= '0;
			valid_q <= 1'b0; mode_q <= 1'b1;
			i_q <= '0; j_q <= '0; c_q <= '0; len_q <= '0; prev_q <= '0;
			k_q <= '0; kend_q <= '0; sw_q <= '0; u_q <= '0;
			p1_q <= 1'b0; p2_q <= 1'b0;
			s1_v_q <= 1'b0; s1_q <= '0;
			m_tvalid_q <= 1'b0;
			o_status_q <= '0; o_ans_q <= '0; o_cval_q <= '0; o_tally_q <= '0; o_total_q <= '0;
		end else begin
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end
			// pending answer word moves into the output register
			if (s1_v_q && out_free) begin
				m_tvalid_q <= 1'b1;
				o_status_q <= s1_q.status;
				o_ans_q <= s1_q.ans;
				o_total_q <= s1_q.total;
				o_cval_q <= (s1_q.kind == ggc_pkg::K_VERTEX && s1_q.status == ggc_pkg::ST_OK) ?
				            10'(vc_rdata) : 10'd0;
				o_tally_q <= (s1_q.kind == ggc_pkg::K_TALLY && s1_q.status == ggc_pkg::ST_OK) ?
				             11'(ta_rdata) : 11'd0;
			end else if (m_tready && !done_fire) begin
				m_tvalid_q <= 1'b0;
			end
			if (s1_set) begin
				s1_v_q <= 1'b1;
			end else if (s1_v_q && out_free) begin
				s1_v_q <= 1'b0;
			end
			p1_q <= (state_q == S_C_NB) && (k_q != kend_q);
			p2_q <= p1_q;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						s1_q.total <= 11'(colors_q);
						s1_q.ans <= 10'd0;
						s1_q.kind <= ggc_pkg::K_FIXED;
						s1_q.status <= ggc_pkg::ST_RANGE;
						case (op)
							ggc_pkg::OP_ADD: begin
								if (add_ok) begin
									entries_q <= entries_q + EW'(1);
									valid_q <= 1'b0;
								end
							end
							ggc_pkg::OP_END: begin
								if (end_ok) begin
									rows_q <= rows_q + NW'(1);
									valid_q <= 1'b0;
								end
							end
							ggc_pkg::OP_COLOR: begin
								colors_q <= '0;
								sw_q <= '0;
								state_q <= S_SWEEP;
							end
							ggc_pkg::OP_RDV, ggc_pkg::OP_RDT: begin
								s1_q.ans <= qidx;
								s1_q.kind <= (op == ggc_pkg::OP_RDV) ? ggc_pkg::K_VERTEX :
								             ggc_pkg::K_TALLY;
								if (!valid_q) begin
									s1_q.status <= ggc_pkg::ST_NOCOL;
								end else if ((op == ggc_pkg::OP_RDV) ? rdv_ok : rdt_ok) begin
									s1_q.status <= ggc_pkg::ST_OK;
								end
							end
							ggc_pkg::OP_CLR: begin
								rows_q <= '0;
								entries_q <= '0;
								colors_q <= '0;
								valid_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_SWEEP: begin
					sw_q <= sw_q + VW'(1);
					i_q <= '0;
					prev_q <= '0;
					if (sw_q == VW'(MAXV - 1)) begin
						state_q <= (rows_q == '0) ? S_DONE : S_LEN_RD;
					end
				end
				S_LEN_RD: state_q <= S_LEN;
				S_LEN: begin
					len_q <= len_now;
					prev_q <= re_rdata;
					j_q <= i_q;
					if (direct) begin
						i_q <= last_i ? '0 : i_inc;
						state_q <= last_i ? S_C_ORD : S_LEN_RD;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (shift) begin
						j_q <= jm1;
						if (j_q == NW'(1)) begin
							state_q <= S_PLACE;
						end
					end else begin
						i_q <= last_i ? '0 : i_inc;
						state_q <= last_i ? S_C_ORD : S_LEN_RD;
					end
				end
				S_PLACE: begin
					i_q <= last_i ? '0 : i_inc;
					state_q <= last_i ? S_C_ORD : S_LEN_RD;
				end
				S_C_ORD: state_q <= S_C_ROW;
				S_C_ROW: begin
					u_q <= ord_rdata[OW-1:EW];
					len_q <= ord_rdata[EW-1:0];
					state_q <= S_C_RANGE;
				end
				S_C_RANGE: begin
					k_q <= re_rdata - len_q;
					kend_q <= re_rdata;
					state_q <= S_C_NB;
				end
				S_C_NB: begin
					if (k_q != kend_q) begin
						k_q <= k_q + EW'(1);
					end else begin
						state_q <= S_C_DRAIN;
					end
				end
				S_C_DRAIN: begin
					c_q <= '0;
					if (!p1_q && !p2_q) begin
						state_q <= S_C_SRCH;
					end
				end
				S_C_SRCH: state_q <= (c_q == colors_q) ? S_C_TRD : S_C_CHK;
				S_C_CHK: begin
					if (sn_rdata == i_q) begin
						c_q <= c_q + NW'(1);
						state_q <= S_C_SRCH;
					end else begin
						state_q <= S_C_TRD;
					end
				end
				S_C_TRD: state_q <= S_C_TWR;
				S_C_TWR: begin
					if (c_q == colors_q) begin
						colors_q <= colors_q + NW'(1);
					end
					i_q <= i_inc;
					state_q <= last_i ? S_DONE : S_C_ORD;
				end
				S_DONE: begin
					if (done_fire) begin
						valid_q <= 1'b1;
						m_tvalid_q <= 1'b1;
						o_status_q <= ggc_pkg::ST_OK;
						o_ans_q <= '0;
						o_cval_q <= '0;
						o_tally_q <= '0;
						o_total_q <= 11'(colors_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, o_total_q, o_tally_q, o_cval_q, o_ans_q, o_status_q};

endmodule

// File: hdl/ggc_checker.sv
// port level checks for the graph coloring block, bound to the top level
module ggc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        cfg_wen,
	input logic        cfg_wdata
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("unknown status code");

	// failed or uncolored answers carry no color and no tally
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ggc_pkg::ST_RANGE || m_tdata[1:0] == ggc_pkg::ST_NOCOL)
		|-> m_tdata[21:12] == 10'd0 && m_tdata[32:22] == 11'd0)
		else $error("data on a failed answer");

	// an offered command word waits unchanged until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("command word changed before it was taken");

	// mode writes only land while both streams are quiet
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |-> !s_tvalid && !m_tvalid && !$isunknown(cfg_wdata))
		else $error("mode write while words are in flight");

endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (.*);

// File: sim/tb_top.sv
// testbench for greedy_graph_coloring: directed table, random graphs, predictor check
`timescale 1ns / 100ps

module tb_top;

	localparam int NV = 1024;
	localparam int NE = 8192;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  ans;
		logic [9:0]  cval;
		logic [10:0] tally;
		logic [10:0] total;
	} answer_t;

	typedef struct {
		ggc_pkg::opcode_t op;
		logic [9:0]  col;
		logic [9:0]  q;
		bit          check_fixed;
		answer_t     fixed;
	} cmd_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;
	logic cfg_wen = 0;
	logic cfg_wdata = 0;

	greedy_graph_coloring dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// predictor state
	bit        pr_mode;
	int        pr_row_start[NV+1];
	int        pr_nbr[NE];
	int        pr_color[NV];
	int        pr_seen[NV];
	int        pr_tally[NV];
	int        pr_order[NV];
	int        pr_rows, pr_entries, pr_colors;
	bit        pr_valid;

	answer_t   expected_q[$];
	answer_t   fixed_q[$];
	bit        fixed_flag_q[$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        hold_long = 0;

	function automatic void clear_model();
		pr_row_start[0] = 0;
		foreach (pr_color[i]) begin
			pr_color[i] = NV;
			pr_seen[i] = NV;
			pr_tally[i] = 0;
		end
		pr_rows = 0;
		pr_entries = 0;
		pr_colors = 0;
		pr_valid = 0;
	endfunction

	function automatic int row_len(int r);
		return pr_row_start[r+1] - pr_row_start[r];
	endfunction

	function automatic void run_coloring();
		int v, j, u, c, nb;
		foreach (pr_color[i]) begin
			pr_color[i] = NV;
			pr_seen[i] = NV;
			pr_tally[i] = 0;
		end
		pr_colors = 0;
		for (int i = 0; i < pr_rows; i++) pr_order[i] = i;
		if (pr_mode) begin
			for (int i = 1; i < pr_rows; i++) begin
				v = pr_order[i];
				j = i;
				while (j > 0 && row_len(pr_order[j-1]) < row_len(v)) begin
					pr_order[j] = pr_order[j-1];
					j--;
				end
				pr_order[j] = v;
			end
		end
		for (int i = 0; i < pr_rows; i++) begin
			u = pr_order[i];
			for (int k = pr_row_start[u]; k < pr_row_start[u+1] && k < NE; k++) begin
				nb = pr_nbr[k];
				if (nb < NV && pr_color[nb] != NV) pr_seen[pr_color[nb]] = i;
			end
			c = 0;
			while (c < pr_colors && pr_seen[c] == i) c++;
			if (c == pr_colors) pr_colors++;
			pr_color[u] = c;
			pr_tally[c]++;
		end
		pr_valid = 1;
	endfunction

	// returns 1 and fills res when the command yields a word
	function automatic bit predict_cmd(ggc_pkg::opcode_t op, int col, int q,
			output answer_t res);
		res = '0;
		case (op)
			ggc_pkg::OP_ADD: begin
				if (pr_rows >= NV || pr_entries >= NE || col >= NV)
					res.status = ggc_pkg::ST_RANGE;
				else begin
					pr_nbr[pr_entries] = col;
					pr_entries++;
					pr_valid = 0;
					return 0;
				end
			end
			ggc_pkg::OP_END: begin
				if (pr_rows >= NV) res.status = ggc_pkg::ST_RANGE;
				else begin
					pr_rows++;
					pr_row_start[pr_rows] = pr_entries;
					pr_valid = 0;
					return 0;
				end
			end
			ggc_pkg::OP_COLOR: run_coloring();
			ggc_pkg::OP_RDV: begin
				res.ans = q;
				if (!pr_valid) res.status = ggc_pkg::ST_NOCOL;
				else if (q >= pr_rows) res.status = ggc_pkg::ST_RANGE;
				else res.cval = pr_color[q];
			end
			ggc_pkg::OP_RDT: begin
				res.ans = q;
				if (!pr_valid) res.status = ggc_pkg::ST_NOCOL;
				else if (q >= pr_colors) res.status = ggc_pkg::ST_RANGE;
				else res.tally = pr_tally[q];
			end
			ggc_pkg::OP_CLR: begin
				clear_model();
				return 0;
			end
			default: return 0;
		endcase
		res.total = pr_colors;
		return 1;
	endfunction

	task automatic send_cmd(logic [2:0] op, int col, int q, bit has_fixed = 0,
			answer_t fixed = '0);
		answer_t res;
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		s_tdata <= {1'b0, q[9:0], col[9:0], op};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		if (predict_cmd(ggc_pkg::opcode_t'(op), col & 'h3ff, q & 'h3ff, res)) begin
			expected_q.push_back(res);
			fixed_q.push_back(fixed);
			fixed_flag_q.push_back(has_fixed);
		end
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_mode(bit m);
		drain();
		cfg_wdata <= m;
		cfg_wen <= 1;
		@(negedge clk);
		cfg_wen <= 0;
		pr_mode = m;
	endtask

	// receiver: random stalls, and one long hold-off
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				m_tready <= 0;
				repeat (300) @(negedge clk);
				hold_long = 0;
			end
			gap = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// checker
	always @(posedge clk) begin
		answer_t got, exp;
		answer_t fx;
		bit use_fx;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[43:33], m_tdata[32:22], m_tdata[21:12], m_tdata[11:2],
				m_tdata[1:0]} == 0 ? '0 : '0;
			got.status = m_tdata[1:0];
			got.ans = m_tdata[11:2];
			got.cval = m_tdata[21:12];
			got.tally = m_tdata[32:22];
			got.total = m_tdata[43:33];
			if (expected_q.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				fx = fixed_q.pop_front();
				use_fx = fixed_flag_q.pop_front();
				if (use_fx && fx != exp) begin
					$error("table entry disagrees with predictor: %h vs %h", fx, exp);
					errors++;
				end
				if (got.status != exp.status) begin
					$error("status: expected %0d got %0d", exp.status, got.status); errors++;
				end
				if (got.ans != exp.ans) begin
					$error("answer_index: expected %0d got %0d", exp.ans, got.ans); errors++;
				end
				if (got.cval != exp.cval) begin
					$error("color_value: expected %0d got %0d", exp.cval, got.cval); errors++;
				end
				if (got.tally != exp.tally) begin
					$error("vertex_tally: expected %0d got %0d", exp.tally, got.tally);
					errors++;
				end
				if (got.total != exp.total) begin
					$error("color_total: expected %0d got %0d", exp.total, got.total);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// random graph: mostly well formed rows, some noise
	task automatic random_graph(int nrows, int maxlen, int nreads);
		int len;
		for (int r = 0; r < nrows; r++) begin
			len = $urandom_range(0, maxlen);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 15) == 0)
					send_cmd(ggc_pkg::OP_ADD, $urandom_range(0, 1023), 0);
				else send_cmd(ggc_pkg::OP_ADD, $urandom_range(0, nrows + 1), $urandom);
			end
			send_cmd(ggc_pkg::OP_END, $urandom, $urandom);
		end
		if ($urandom_range(0, 3) == 0)
			send_cmd(ggc_pkg::OP_ADD, $urandom_range(0, nrows), 0);
		send_cmd(ggc_pkg::OP_COLOR, $urandom, $urandom);
		for (int i = 0; i < nreads; i++) begin
			case ($urandom_range(0, 5))
				0: send_cmd(ggc_pkg::OP_RDV, $urandom, $urandom_range(0, 1023));
				1, 2: send_cmd(ggc_pkg::OP_RDV, $urandom, $urandom_range(0, nrows));
				3: send_cmd(ggc_pkg::OP_RDT, $urandom, $urandom_range(0, 1023));
				4: send_cmd($urandom_range(6, 7), $urandom, $urandom);
				default: send_cmd(ggc_pkg::OP_RDT, $urandom, $urandom_range(0, 6));
			endcase
		end
		send_cmd(ggc_pkg::OP_CLR, $urandom, $urandom);
	endtask

	initial begin
		cmd_row_t tbl[$];
		answer_t a;
		pr_mode = 1;
		clear_model();
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reads before coloring, empty graph, small triangle plus pendant
		a = '0; a.status = ggc_pkg::ST_NOCOL; a.ans = 10'd1023;
		tbl.push_back('{ggc_pkg::OP_RDV, 0, 1023, 1, a});
		a = '0; a.status = ggc_pkg::ST_NOCOL;
		tbl.push_back('{ggc_pkg::OP_RDT, 0, 0, 1, a});
		a = '0;
		tbl.push_back('{ggc_pkg::OP_COLOR, 0, 0, 1, a});
		a = '0; a.status = ggc_pkg::ST_RANGE;
		tbl.push_back('{ggc_pkg::OP_RDV, 0, 0, 1, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 1, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 2, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_END, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 2, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 1023, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_END, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 1, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 3, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_END, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 2, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_END, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_ADD, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_COLOR, 0, 0, 0, a});
		tbl.push_back('{ggc_pkg::OP_RDV, 0, 2, 0, a});
		tbl.push_back('{ggc_pkg::OP_RDV, 0, 3, 0, a});
		tbl.push_back('{ggc_pkg::OP_RDT, 0, 2, 0, a});
		tbl.push_back('{ggc_pkg::OP_RDT, 0, 1023, 0, a});
		tbl.push_back('{ggc_pkg::opcode_t'(3'd7), 10'h3ff, 10'h3ff, 0, a});
		tbl.push_back('{ggc_pkg::OP_CLR, 0, 0, 0, a});
		foreach (tbl[i]) send_cmd(tbl[i].op, tbl[i].col, tbl[i].q, tbl[i].check_fixed,
			tbl[i].fixed);

		// natural order, then back to longest first
		write_mode(0);
		random_graph(6, 4, 8);
		hold_long = 1;
		random_graph(10, 5, 20);
		drain();
		write_mode(1);
		for (int g = 0; g < 14; g++) begin
			random_graph($urandom_range(1, 12), $urandom_range(0, 6), 12);
			if (g == 4) write_mode(0);
			if (g == 7) write_mode(1);
		end
		random_graph(8, 4, 10);

		drain();
		repeat (100) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
